/* hw/rtl/mdct_pkg.sv */
package mdct_pkg;

   localparam int PW  = 16;          // input position and velocity width
   localparam int DW  = PW + 1;      // relative position and velocity width
   localparam int PRW = 2 * DW;      // product of two differences
   localparam int AW  = 34;          // a = |dv|^2, unsigned
   localparam int HW  = 35;          // h = dv.dp and c, signed
   localparam int MW  = 34;          // magnitude of h and of c
   localparam int DSW = 70;          // discriminant h^2 - a*c
   localparam int XW  = DSW + 32;    // discriminant scaled by 2^32
   localparam int SW  = XW / 2;      // square root width
   localparam int RW  = SW + 3;      // square root partial remainder
   localparam int BW  = 53;          // base = -h * 2^16, signed
   localparam int NW  = 54;          // numerators base -/+ root, signed
   localparam int QW  = 53;          // quotient magnitude width
   localparam int RDW = AW + 1;      // divider partial remainder
   localparam int TW  = 32;          // Q16.16 time width

   typedef struct packed {
      logic                 valid;
      logic signed [PW-1:0] first_pos_x;
      logic signed [PW-1:0] first_pos_y;
      logic signed [PW-1:0] first_vel_x;
      logic signed [PW-1:0] first_vel_y;
      logic signed [PW-1:0] second_pos_x;
      logic signed [PW-1:0] second_pos_y;
      logic signed [PW-1:0] second_vel_x;
      logic signed [PW-1:0] second_vel_y;
      logic        [PW-1:0] detect_radius;
   } in_type;

   typedef struct packed {
      logic                 valid;
      logic                 nocoll;
      logic        [AW-1:0] a;
      logic signed [BW-1:0] base;
   } side_type;

   typedef struct packed {
      logic          valid;
      logic          nocoll;
      logic [AW-1:0] a;
      logic          neg1;
      logic          neg2;
   } divside_type;

   typedef struct packed {
      logic                 valid;
      logic                 collides;
      logic signed [TW-1:0] time_first;
      logic signed [TW-1:0] time_second;
   } out_type;

   // Floor quotient from sign, truncated magnitude and remainder flag,
   // saturated to signed Q16.16.
   function automatic logic [TW-1:0] sat_time(logic neg, logic [QW-1:0] q, logic rnz);
      logic [QW:0] m;
      m = {1'b0, q} + {{QW{1'b0}}, (neg & rnz)};
      if (!neg) begin
         if (q[QW-1:TW-1] != '0) return {1'b0, {(TW-1){1'b1}}};
         else return q[TW-1:0];
      end else begin
         if (m[QW:TW] != '0 || (m[TW-1] && m[TW-2:0] != '0))
            return {1'b1, {(TW-1){1'b0}}};
         else return ~m[TW-1:0] + {{(TW-1){1'b0}}, 1'b1};
      end
   endfunction

endpackage

/* hw/rtl/mdct_front.sv */
// Differences, products and discriminant in five register stages.
module mdct_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  mdct_pkg::in_type            in_i,
   output mdct_pkg::side_type          side_o,
   output logic [mdct_pkg::XW-1:0]     x_o
);

   // Stage 1: relative position and velocity.
   logic                              v1_ff;
   logic signed [mdct_pkg::DW-1:0]    dpx_ff, dpy_ff, dvx_ff, dvy_ff;
   logic        [mdct_pkg::PW-1:0]    rad1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff   <= in_i.valid;
         dpx_ff  <= {in_i.first_pos_x[15], in_i.first_pos_x}
                    - {in_i.second_pos_x[15], in_i.second_pos_x};
         dpy_ff  <= {in_i.first_pos_y[15], in_i.first_pos_y}
                    - {in_i.second_pos_y[15], in_i.second_pos_y};
         dvx_ff  <= {in_i.first_vel_x[15], in_i.first_vel_x}
                    - {in_i.second_vel_x[15], in_i.second_vel_x};
         dvy_ff  <= {in_i.first_vel_y[15], in_i.first_vel_y}
                    - {in_i.second_vel_y[15], in_i.second_vel_y};
         rad1_ff <= in_i.detect_radius;
      end
   end

   // Stage 2: the six products.
   logic                              v2_ff;
   logic signed [mdct_pkg::PRW-1:0]   vxx_ff, vyy_ff, vpx_ff, vpy_ff, pxx_ff, pyy_ff;
   logic        [mdct_pkg::PW-1:0]    rad2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff   <= v1_ff;
         vxx_ff  <= dvx_ff * dvx_ff;
         vyy_ff  <= dvy_ff * dvy_ff;
         vpx_ff  <= dvx_ff * dpx_ff;
         vpy_ff  <= dvy_ff * dpy_ff;
         pxx_ff  <= dpx_ff * dpx_ff;
         pyy_ff  <= dpy_ff * dpy_ff;
         rad2_ff <= rad1_ff;
      end
   end

   // Stage 3: a, h, c and the scaled base term.
   logic                              v3_ff;
   logic        [mdct_pkg::AW-1:0]    a3_ff;
   logic signed [mdct_pkg::HW-1:0]    h3_ff, c3_ff;
   logic signed [mdct_pkg::BW-1:0]    base3_ff;
   logic        [mdct_pkg::AW-1:0]    a3_in, psum_in;
   logic signed [mdct_pkg::HW-1:0]    h3_in, c3_in;

   always_comb begin
      a3_in   = vxx_ff[mdct_pkg::AW-1:0] + vyy_ff[mdct_pkg::AW-1:0];
      psum_in = pxx_ff[mdct_pkg::AW-1:0] + pyy_ff[mdct_pkg::AW-1:0];
      h3_in   = {vpx_ff[mdct_pkg::PRW-1], vpx_ff} + {vpy_ff[mdct_pkg::PRW-1], vpy_ff};
      c3_in   = $signed({1'b0, psum_in}) - $signed({3'b000, rad2_ff, 16'h0000});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff    <= v2_ff;
         a3_ff    <= a3_in;
         h3_ff    <= h3_in;
         c3_ff    <= c3_in;
         base3_ff <= -($signed({{(mdct_pkg::BW-mdct_pkg::HW-16){h3_in[mdct_pkg::HW-1]}},
                                h3_in, 16'h0000}));
      end
   end

   // Stage 4: h^2 and a*|c|.
   logic                              v4_ff, cpos4_ff;
   logic        [mdct_pkg::AW-1:0]    a4_ff;
   logic signed [mdct_pkg::BW-1:0]    base4_ff;
   logic        [2*mdct_pkg::MW-1:0]  hsq_ff, ac_ff;
   logic        [mdct_pkg::HW-1:0]    hneg, cneg;
   logic        [mdct_pkg::MW-1:0]    hmag, cmag;

   always_comb begin
      hneg = -h3_ff;
      cneg = -c3_ff;
      hmag = h3_ff[mdct_pkg::HW-1] ? hneg[mdct_pkg::MW-1:0] : h3_ff[mdct_pkg::MW-1:0];
      cmag = c3_ff[mdct_pkg::HW-1] ? cneg[mdct_pkg::MW-1:0] : c3_ff[mdct_pkg::MW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff    <= v3_ff;
         a4_ff    <= a3_ff;
         base4_ff <= base3_ff;
         cpos4_ff <= !c3_ff[mdct_pkg::HW-1] && (c3_ff != '0);
         hsq_ff   <= hmag * hmag;
         ac_ff    <= a3_ff * cmag;
      end
   end

   // Stage 5: discriminant and the no-collision flag.
   logic [mdct_pkg::DSW-1:0] disc_in;
   logic                     neg_in;
   mdct_pkg::side_type       side_ff;
   logic [mdct_pkg::DSW-1:0] disc_ff;

   always_comb begin
      neg_in = cpos4_ff && (hsq_ff < ac_ff);
      if (cpos4_ff) disc_in = {2'b00, hsq_ff} - {2'b00, ac_ff};
      else          disc_in = {2'b00, hsq_ff} + {2'b00, ac_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff.valid  <= v4_ff;
         side_ff.nocoll <= neg_in || (a4_ff == '0);
         side_ff.a      <= a4_ff;
         side_ff.base   <= base4_ff;
         disc_ff        <= disc_in;
      end
   end

   assign side_o = side_ff;
   assign x_o    = {disc_ff, 32'h0000_0000};

endmodule

/* hw/rtl/mdct_sqrt.sv */
// Digit-by-digit integer square root, one result bit per register stage.
module mdct_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  mdct_pkg::side_type          side_i,
   input  logic [mdct_pkg::XW-1:0]     x_i,
   output mdct_pkg::side_type          side_o,
   output logic [mdct_pkg::SW-1:0]     root_o
);

   mdct_pkg::side_type          side_ff [mdct_pkg::SW];
   logic [mdct_pkg::XW-1:0]     x_ff    [mdct_pkg::SW];
   logic [mdct_pkg::RW-1:0]     rem_ff  [mdct_pkg::SW];
   logic [mdct_pkg::SW-1:0]     root_ff [mdct_pkg::SW];

   for (genvar k = 0; k < mdct_pkg::SW; k++) begin : stage_g
      mdct_pkg::side_type      sp;
      logic [mdct_pkg::XW-1:0] xp;
      logic [mdct_pkg::RW-1:0] rp, remsh, trial, rem_in;
      logic [mdct_pkg::SW-1:0] qp;
      logic                    ge;

      if (k == 0) begin : first_g
         assign sp = side_i;
         assign xp = x_i;
         assign rp = '0;
         assign qp = '0;
      end else begin : next_g
         assign sp = side_ff[k-1];
         assign xp = x_ff[k-1];
         assign rp = rem_ff[k-1];
         assign qp = root_ff[k-1];
      end

      always_comb begin
         remsh  = {rp[mdct_pkg::RW-3:0], xp[mdct_pkg::XW-1 -: 2]};
         trial  = {{(mdct_pkg::RW-mdct_pkg::SW-2){1'b0}}, qp, 2'b01};
         ge     = (remsh >= trial);
         rem_in = ge ? (remsh - trial) : remsh;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k].valid <= 1'b0;
         end else if (en) begin
            side_ff[k] <= sp;
            x_ff[k]    <= {xp[mdct_pkg::XW-3:0], 2'b00};
            rem_ff[k]  <= rem_in;
            root_ff[k] <= {qp[mdct_pkg::SW-2:0], ge};
         end
      end
   end

   assign side_o = side_ff[mdct_pkg::SW-1];
   assign root_o = root_ff[mdct_pkg::SW-1];

endmodule

/* hw/rtl/mdct_div.sv */
// Two restoring dividers side by side, one quotient bit per stage, then
// floor correction and saturation.
module mdct_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  mdct_pkg::side_type          side_i,
   input  logic [mdct_pkg::SW-1:0]     root_i,
   output mdct_pkg::out_type           out_o
);

   // Numerators and their signs.
   mdct_pkg::divside_type       d0_ff;
   logic [mdct_pkg::QW-1:0]     m10_ff, m20_ff;
   logic signed [mdct_pkg::NW-1:0] n1, n2, bx, sx;

   always_comb begin
      bx = {{(mdct_pkg::NW-mdct_pkg::BW){side_i.base[mdct_pkg::BW-1]}}, side_i.base};
      sx = $signed({{(mdct_pkg::NW-mdct_pkg::SW){1'b0}}, root_i});
      n1 = bx - sx;
      n2 = bx + sx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_ff.valid <= 1'b0;
      end else if (en) begin
         d0_ff.valid  <= side_i.valid;
         d0_ff.nocoll <= side_i.nocoll;
         d0_ff.a      <= side_i.a;
         d0_ff.neg1   <= n1[mdct_pkg::NW-1];
         d0_ff.neg2   <= n2[mdct_pkg::NW-1];
         m10_ff <= n1[mdct_pkg::NW-1] ? mdct_pkg::QW'(-n1) : n1[mdct_pkg::QW-1:0];
         m20_ff <= n2[mdct_pkg::NW-1] ? mdct_pkg::QW'(-n2) : n2[mdct_pkg::QW-1:0];
      end
   end

   mdct_pkg::divside_type       ds_ff [mdct_pkg::QW];
   logic [mdct_pkg::QW-1:0]     m1_ff [mdct_pkg::QW], m2_ff [mdct_pkg::QW];
   logic [mdct_pkg::QW-1:0]     q1_ff [mdct_pkg::QW], q2_ff [mdct_pkg::QW];
   logic [mdct_pkg::RDW-1:0]    r1_ff [mdct_pkg::QW], r2_ff [mdct_pkg::QW];

   for (genvar k = 0; k < mdct_pkg::QW; k++) begin : stage_g
      mdct_pkg::divside_type    sp;
      logic [mdct_pkg::QW-1:0]  m1p, m2p, q1p, q2p;
      logic [mdct_pkg::RDW-1:0] r1p, r2p, s1, s2, dvs, r1_in, r2_in;
      logic                     ge1, ge2;

      if (k == 0) begin : first_g
         assign sp  = d0_ff;
         assign m1p = m10_ff;
         assign m2p = m20_ff;
         assign q1p = '0;
         assign q2p = '0;
         assign r1p = '0;
         assign r2p = '0;
      end else begin : next_g
         assign sp  = ds_ff[k-1];
         assign m1p = m1_ff[k-1];
         assign m2p = m2_ff[k-1];
         assign q1p = q1_ff[k-1];
         assign q2p = q2_ff[k-1];
         assign r1p = r1_ff[k-1];
         assign r2p = r2_ff[k-1];
      end

      always_comb begin
         dvs   = {1'b0, sp.a};
         s1    = {r1p[mdct_pkg::RDW-2:0], m1p[mdct_pkg::QW-1]};
         s2    = {r2p[mdct_pkg::RDW-2:0], m2p[mdct_pkg::QW-1]};
         ge1   = (s1 >= dvs);
         ge2   = (s2 >= dvs);
         r1_in = ge1 ? (s1 - dvs) : s1;
         r2_in = ge2 ? (s2 - dvs) : s2;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ds_ff[k].valid <= 1'b0;
         end else if (en) begin
            ds_ff[k] <= sp;
            m1_ff[k] <= {m1p[mdct_pkg::QW-2:0], 1'b0};
            m2_ff[k] <= {m2p[mdct_pkg::QW-2:0], 1'b0};
            q1_ff[k] <= {q1p[mdct_pkg::QW-2:0], ge1};
            q2_ff[k] <= {q2p[mdct_pkg::QW-2:0], ge2};
            r1_ff[k] <= r1_in;
            r2_ff[k] <= r2_in;
         end
      end
   end

   // Final stage: floor, saturate, and zero out the no-collision cases.
   mdct_pkg::divside_type ls;
   mdct_pkg::out_type     out_ff;

   assign ls = ds_ff[mdct_pkg::QW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff.valid    <= ls.valid;
         out_ff.collides <= !ls.nocoll;
         out_ff.time_first <= ls.nocoll ? '0 :
            mdct_pkg::sat_time(ls.neg1, q1_ff[mdct_pkg::QW-1], r1_ff[mdct_pkg::QW-1] != '0);
         out_ff.time_second <= ls.nocoll ? '0 :
            mdct_pkg::sat_time(ls.neg2, q2_ff[mdct_pkg::QW-1], r2_ff[mdct_pkg::QW-1] != '0);
      end
   end

   assign out_o = out_ff;

endmodule

/* hw/rtl/moving_disc_collision_time_top.sv */
// Collision time of two discs moving in straight lines.
//
// The request channel carries the positions and velocities of two particles
// (signed Q8.8) and a detection radius. Each request transfer yields exactly
// one response transfer, in order, with a collision flag and the smaller and
// larger root of the closing quadratic in signed Q16.16, saturated. When the
// particles never come in range, or have no relative motion, the flag and
// both times are zero.
//
// The block is one pipeline of 111 register stages: five for differences,
// products and the discriminant, 51 for the square root (one bit a stage),
// one to form the numerators, 53 for the two dividers (one quotient bit a
// stage) and one for rounding and saturation. While the receiver does not
// stall a valid response, one request is taken every cycle.
//
// Synchronous reset empties the pipeline. When the receiver stalls a valid
// response, the whole pipeline holds and req_stall goes high, so no item is
// lost or repeated; empty stages fill while no response waits.
module moving_disc_collision_time_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [15:0] req_first_pos_x,
   input  logic signed [15:0] req_first_pos_y,
   input  logic signed [15:0] req_first_vel_x,
   input  logic signed [15:0] req_first_vel_y,
   input  logic signed [15:0] req_second_pos_x,
   input  logic signed [15:0] req_second_pos_y,
   input  logic signed [15:0] req_second_vel_x,
   input  logic signed [15:0] req_second_vel_y,
   input  logic        [15:0] req_detect_radius,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_collides,
   output logic signed [31:0] rsp_time_first,
   output logic signed [31:0] rsp_time_second
);

   mdct_pkg::in_type          in_req;
   mdct_pkg::side_type        front_side, sqrt_side;
   mdct_pkg::out_type         result;
   logic [mdct_pkg::XW-1:0]   front_x;
   logic [mdct_pkg::SW-1:0]   sqrt_root;
   logic                      en;

   // Every stage advances unless a finished response is being held.
   assign en        = !result.valid || !rsp_stall;
   assign req_stall = !en;

   always_comb begin
      in_req.valid         = req_valid;
      in_req.first_pos_x   = req_first_pos_x;
      in_req.first_pos_y   = req_first_pos_y;
      in_req.first_vel_x   = req_first_vel_x;
      in_req.first_vel_y   = req_first_vel_y;
      in_req.second_pos_x  = req_second_pos_x;
      in_req.second_pos_y  = req_second_pos_y;
      in_req.second_vel_x  = req_second_vel_x;
      in_req.second_vel_y  = req_second_vel_y;
      in_req.detect_radius = req_detect_radius;
   end

   mdct_front u_front (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .in_i   (in_req),
      .side_o (front_side),
      .x_o    (front_x)
   );

   mdct_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .side_i (front_side),
      .x_i    (front_x),
      .side_o (sqrt_side),
      .root_o (sqrt_root)
   );

   mdct_div u_div (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .side_i (sqrt_side),
      .root_i (sqrt_root),
      .out_o  (result)
   );

   assign rsp_valid       = result.valid;
   assign rsp_collides    = result.collides;
   assign rsp_time_first  = result.time_first;
   assign rsp_time_second = result.time_second;

`ifndef SYNTH
   // A response with no collision carries zero times.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_collides |-> rsp_time_first == 0 && rsp_time_second == 0)
      else $error("no-collision response with nonzero time");

   // The smaller root never exceeds the larger one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_collides |-> rsp_time_first <= rsp_time_second)
      else $error("collision times out of order");

   // A held response freezes the request side too.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response held");
`endif

endmodule

/* verif/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // One expected outcome of a particle pair.
   typedef struct {
      logic        collides;
      logic [31:0] t_first;
      logic [31:0] t_second;
   } hit_type;

   // Tracks expected collision outcomes in transfer order and checks each response.
   class hit_scoreboard;
      hit_type pending[$];
      int      errors;
      int      checked;
      int      hits;

      // Floor division of n by a positive d, saturated to signed Q16.16.
      function automatic logic [31:0] floor_sat(longint signed n, longint signed d);
         longint signed q;
         q = n / d;
         if ((n % d) != 0 && n < 0) q = q - 1;
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
         return q[31:0];
      endfunction

      // Integer square root by bit-serial search over a 102-bit value.
      function automatic logic [52:0] root_floor(logic [127:0] x);
         logic [52:0]  r;
         logic [52:0]  cand;
         logic [127:0] sq;
         r = '0;
         for (int b = 52; b >= 0; b--) begin
            cand = r | (53'd1 << b);
            sq = {75'd0, cand} * {75'd0, cand};
            if (sq <= x) r = cand;
         end
         return r;
      endfunction

      function void note_pair(logic signed [15:0] p1x, p1y, v1x, v1y,
                              p2x, p2y, v2x, v2y, logic [15:0] rad);
         longint signed dpx, dpy, dvx, dvy, a, h, c, base;
         logic signed [127:0] d;
         logic [52:0] s;
         hit_type e;
         dpx = longint'(p1x) - longint'(p2x);
         dpy = longint'(p1y) - longint'(p2y);
         dvx = longint'(v1x) - longint'(v2x);
         dvy = longint'(v1y) - longint'(v2y);
         a = dvx * dvx + dvy * dvy;
         h = dvx * dpx + dvy * dpy;
         c = dpx * dpx + dpy * dpy - longint'(rad) * 65536;
         e.collides = 1'b0;
         e.t_first = '0;
         e.t_second = '0;
         if (a != 0) begin
            d = 128'(h) * 128'(h) - 128'(a) * 128'(c);
            if (d >= 0) begin
               s = root_floor(128'(d) << 32);
               base = -h * 65536;
               e.collides = 1'b1;
               e.t_first = floor_sat(base - longint'(s), a);
               e.t_second = floor_sat(base + longint'(s), a);
            end
         end
         pending.push_back(e);
      endfunction

      function void check_hit(logic col, logic [31:0] tf, logic [31:0] ts);
         hit_type e;
         if (pending.size() == 0) begin
            $display("%0t: response with nothing expected: expected none, actual %b %h %h",
                     $time, col, tf, ts);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (col) hits++;
         if (col !== e.collides) begin
            $display("%0t: collides expected %b actual %b", $time, e.collides, col);
            errors++;
         end
         if (tf !== e.t_first) begin
            $display("%0t: time_first expected %h actual %h", $time, e.t_first, tf);
            errors++;
         end
         if (ts !== e.t_second) begin
            $display("%0t: time_second expected %h actual %h", $time, e.t_second, ts);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_first_pos_x = '0, req_first_pos_y = '0;
   logic signed [15:0] req_first_vel_x = '0, req_first_vel_y = '0;
   logic signed [15:0] req_second_pos_x = '0, req_second_pos_y = '0;
   logic signed [15:0] req_second_vel_x = '0, req_second_vel_y = '0;
   logic [15:0] req_detect_radius = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic rsp_collides;
   logic signed [31:0] rsp_time_first, rsp_time_second;

   hit_scoreboard board = new();
   // The receiver is held off for a long stretch while this is set.
   bit hold_rsp = 1'b0;

   always #5 clock = ~clock;

   moving_disc_collision_time_top dut (.*);

   // Sends one pair, after a random gap when gapped is set, and waits for its transfer. The payload
   // is kept steady while the block stalls. Valid drops only for a real gap, so
   // back-to-back pairs keep it high; the caller lowers it after the last pair.
   task automatic send_pair(logic [15:0] f[9], bit gapped);
      int gap;
      gap = gapped ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_pos_x <= f[0];
      req_first_pos_y <= f[1];
      req_first_vel_x <= f[2];
      req_first_vel_y <= f[3];
      req_second_pos_x <= f[4];
      req_second_pos_y <= f[5];
      req_second_vel_x <= f[6];
      req_second_vel_y <= f[7];
      req_detect_radius <= f[8];
      do @(posedge clock); while (req_stall);
      board.note_pair(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8]);
   endtask

   // Picks a field: mostly small, so that pairs actually meet, sometimes full range.
   function automatic logic [15:0] pick_field(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 4095)) - 2048);
         default: return 16'($signed($urandom_range(0, 255)) - 128);
      endcase
   endfunction

   task automatic send_random(int count, bit gapped);
      logic [15:0] f[9];
      int mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 4);
         for (int i = 0; i < 8; i++) f[i] = pick_field(mode == 0 ? 0 : (mode < 3 ? 1 : 2));
         // A shared velocity now and then gives the no-relative-motion case.
         if ($urandom_range(0, 15) == 0) begin
            f[6] = f[2];
            f[7] = f[3];
         end
         f[8] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
         send_pair(f, gapped);
      end
   endtask

   // Response side: a random stall per response, or a long hold when asked.
   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end else begin
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_cycles > 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_cycles) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            do @(posedge clock); while (!rsp_valid && !hold_rsp);
         end
      end
   end

   // Every response transfer is checked against the oldest expectation.
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         board.check_hit(rsp_collides, rsp_time_first, rsp_time_second);

   // Directed pairs cover the field extremes and the special cases named for the
   // block, then random traffic follows with gaps, bursts, and a pressure phase.
   initial begin
      logic [15:0] directed[$][9];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // No relative motion, with the pair apart and in range.
      directed.push_back('{16'h0100, 0, 16'h0100, 0, 0, 0, 16'h0100, 0, 16'd0});
      directed.push_back('{0, 0, 16'h0100, 16'h0100, 0, 0, 16'h0100, 16'h0100, 16'd5});
      // Head-on approach along x, and a pair moving apart.
      directed.push_back('{16'hF600, 0, 16'h0100, 0, 16'h0A00, 0, 16'hFF00, 0, 16'd4});
      directed.push_back('{16'hF600, 0, 16'hFF00, 0, 16'h0A00, 0, 16'h0100, 0, 16'd4});
      // Passing wide of each other: negative discriminant.
      directed.push_back('{0, 16'h1000, 16'h0100, 0, 16'h0A00, 0, 0, 0, 16'd1});
      // Glancing contact: offset 2 in y, radius 4 squared-units.
      directed.push_back('{0, 16'h0200, 16'h0100, 0, 16'h0A00, 0, 0, 0, 16'd4});
      // Already in range, and exactly touching.
      directed.push_back('{0, 0, 16'h0100, 0, 16'h0100, 0, 0, 0, 16'd100});
      directed.push_back('{0, 0, 16'h0100, 0, 16'h0200, 0, 0, 0, 16'd4});
      // Field extremes, the largest speeds and distances, and radius extremes.
      directed.push_back('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                           16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF});
      directed.push_back('{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                           16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF});
      directed.push_back('{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                           16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd0});
      directed.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 16'hFFFF});
      directed.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      // Times beyond Q16.16: tiny closing speed over a long distance.
      directed.push_back('{16'h8000, 0, 16'h0001, 0, 16'h7FFF, 0, 0, 0, 16'd1});
      directed.push_back('{16'h7FFF, 0, 16'h0001, 0, 16'h8000, 0, 0, 0, 16'd1});
      directed.push_back('{16'h8000, 0, 16'h0001, 0, 16'h7FFF, 0, 0, 0, 16'hFFFF});
      foreach (directed[k]) send_pair(directed[k], 1'b1);

      send_random(300, 1'b1);

      // The receiver holds off long enough for the pipeline to fill and stall
      // the request side, while pairs keep being offered back to back.
      hold_rsp = 1'b1;
      fork
         send_random(200, 1'b0);
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join
      req_valid <= 1'b0;

      // The sender pauses until every outstanding response has come back.
      while (board.pending.size() != 0) @(posedge clock);
      @(posedge clock);
      send_random(230, 1'b1);
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      $display("Checked %0d responses, %0d with a collision, over directed, gapped,",
               board.checked, board.hits);
      $display("back-to-back and long receiver hold-off traffic.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // The slowest correct run ends well before this timeout, which leaves a wide margin.
   initial begin
      #5ms;
      $display("tb_top: errors");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/mdct_pkg.sv
hw/rtl/mdct_front.sv
hw/rtl/mdct_sqrt.sv
hw/rtl/mdct_div.sv
hw/rtl/moving_disc_collision_time_top.sv
verif/tb_top.sv
